// ===== rtl/core/ghc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// GHC decompressor package
// Shared types and constants for the header decompressor.
// ----------------------------------------------------------------------------
package ghc_pkg;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [63:0] data_bytes;
    logic [3:0]  byte_count;
    logic        run_last;
    logic        packet_end;
    logic [2:0]  status;
    logic [8:0]  total_length;
  } out_t;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_RSV_CODE    = 3'd1;
  localparam logic [2:0] ST_RSV_LITERAL = 3'd2;
  localparam logic [2:0] ST_LIT_OVERRUN = 3'd3;
  localparam logic [2:0] ST_OVERFLOW    = 3'd4;
  localparam logic [2:0] ST_TOO_FAR     = 3'd5;
  localparam logic [2:0] ST_BAD_STOP    = 3'd6;

  localparam logic [2:0] REG_SRC_HI = 3'd0;
  localparam logic [2:0] REG_SRC_LO = 3'd1;
  localparam logic [2:0] REG_DST_HI = 3'd2;
  localparam logic [2:0] REG_DST_LO = 3'd3;
  localparam logic [2:0] REG_LIMIT  = 3'd4;
  localparam logic [2:0] REG_STOP   = 3'd5;

  localparam int DICT_BYTES = 48;
  localparam logic [6:0] LITERAL_MAX = 7'd95;
  localparam logic [9:0] ADJUST_MAX = 10'd1023;
  localparam logic [7:0] HALT_BYTE = 8'h90;

  function automatic logic [7:0] static_byte(input logic [3:0] i);
    case (i)
      4'd0: static_byte = 8'h16;
      4'd1: static_byte = 8'hfe;
      4'd2: static_byte = 8'hfd;
      4'd3: static_byte = 8'h17;
      4'd4: static_byte = 8'hfe;
      4'd5: static_byte = 8'hfd;
      4'd7: static_byte = 8'h01;
      4'd13: static_byte = 8'h01;
      default: static_byte = 8'h00;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ghc_history.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// GHC history store
// One write port and one registered read port over the output history.
// ----------------------------------------------------------------------------
module ghc_history #(
  parameter int DEPTH = 256,
  parameter int AW = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/ghc_header_decompressor.sv =====
`default_nettype none
// A request with no output passes through the emit state back to idle; a literal data
// byte passes through the emit state and a fill-state history read before it comes out.
// A zero run writes one byte per cycle; a backreference passes through the read state
// and then the write state for each byte; a chunk takes one history read per byte.
// One request at a time; the status state sends the final status after the last chunk.
// Reset: rst clears control state and config registers; history store is not cleared.
// ----------------------------------------------------------------------------
// GHC header decompressor
// Decodes an RFC 7400 bytecode stream into output chunks and a final status.
// ----------------------------------------------------------------------------
module ghc_header_decompressor #(
  parameter int OUTPUT_MAX = 256,
  parameter int CHUNK_BYTES = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire ghc_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output ghc_pkg::out_t     out_data,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);
  localparam int AW = $clog2(OUTPUT_MAX);
  localparam int PW = $clog2(OUTPUT_MAX + 1) + 1;
  localparam int CW = $clog2(CHUNK_BYTES + 1);
  localparam logic [PW-1:0] MAXP = PW'(OUTPUT_MAX);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RUN  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_FILL = 3'd5;
  localparam logic [2:0] S_END  = 3'd6;

  logic [63:0] src_hi, src_lo, dst_hi, dst_lo;
  logic [8:0]  output_limit;
  logic        stop_ok;

  logic [2:0]    state;
  logic [PW-1:0] wpos, emit_pos;
  logic [6:0]    lit_pend;
  logic [9:0]    start_adj, num_adj;
  logic          stop_seen;
  logic [2:0]    err;
  logic          last_q, zero_run;
  logic [PW+1:0] src_ptr;
  logic [PW-1:0] remain;
  logic [63:0]   chunk;
  logic [CW-1:0] cnt, cidx;
  logic [7:0]    dict_byte;
  logic          dict_sel;

  logic          h_we;
  logic [AW-1:0] h_waddr, h_raddr;
  logic [7:0]    h_wdata, h_rdata;

  ghc_history #(.DEPTH(OUTPUT_MAX), .AW(AW)) u_hist (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  // Effective limit clamped to the history depth.
  logic [PW-1:0] limit;
  always_comb begin
    if ({{(PW > 9 ? PW-9 : 0){1'b0}}, output_limit} > PW'(OUTPUT_MAX) && PW > 9)
      limit = MAXP;
    else if (PW <= 9 && output_limit > 9'(OUTPUT_MAX))
      limit = MAXP;
    else
      limit = PW'(output_limit);
  end

  function automatic logic [7:0] wbyte(input logic [63:0] w, input logic [2:0] i);
    wbyte = w[8*(7-i) +: 8];
  endfunction

  // A waiting result sits in the output register, so only the sequencer holds input.
  assign in_stall = (state != S_IDLE);
  wire in_acc = in_valid && !in_stall;
  wire out_acc = out_valid && !out_stall;

  wire [7:0] cb = in_data.code_byte;
  wire [10:0] bl_len = 11'(num_adj) + 11'(cb[5:3]) + 11'd2;
  wire [11:0] bl_dist = 12'(cb[2:0]) + 12'(start_adj) + 12'(bl_len);
  wire [11:0] here = 12'(ghc_pkg::DICT_BYTES) + 12'(wpos);
  wire [PW+1:0] here_w = (PW+2)'(ghc_pkg::DICT_BYTES) + (PW+2)'(wpos);
  wire [10:0] s_sum = 11'(start_adj) + 11'({cb[3:0], 3'b000});
  wire [10:0] n_sum = 11'(num_adj) + 11'({cb[4], 3'b000});

  // Registered dictionary byte at src_ptr for the copy loop.
  always_comb begin
    dict_sel = src_ptr < (PW+2)'(ghc_pkg::DICT_BYTES);
    if (src_ptr < (PW+2)'(8)) dict_byte = wbyte(src_hi, src_ptr[2:0]);
    else if (src_ptr < (PW+2)'(16)) dict_byte = wbyte(src_lo, src_ptr[2:0]);
    else if (src_ptr < (PW+2)'(24)) dict_byte = wbyte(dst_hi, src_ptr[2:0]);
    else if (src_ptr < (PW+2)'(32)) dict_byte = wbyte(dst_lo, src_ptr[2:0]);
    else dict_byte = ghc_pkg::static_byte(src_ptr[3:0]);
  end
  logic       dsel_q;
  logic [7:0] dbyte_q;
  wire [PW+1:0] hist_addr = src_ptr - (PW+2)'(ghc_pkg::DICT_BYTES);
  wire [7:0] copy_byte = zero_run ? 8'h00 : (dsel_q ? dbyte_q : h_rdata);

  always_comb begin
    h_we = 1'b0;
    h_waddr = wpos[AW-1:0];
    h_wdata = copy_byte;
    h_raddr = hist_addr[AW-1:0];
    if (state == S_IDLE && in_acc && err == ghc_pkg::ST_OK && !stop_seen &&
        lit_pend != 7'd0) begin
      h_we = 1'b1;
      h_wdata = cb;
    end else if (state == S_WR) begin
      h_we = 1'b1;
    end else if (state == S_FILL) begin
      h_raddr = emit_pos[AW-1:0] + AW'(cidx);
    end
  end

  wire [PW-1:0] avail = wpos - emit_pos;
  wire [CW-1:0] take = (avail > PW'(CHUNK_BYTES)) ? CW'(CHUNK_BYTES) : CW'(avail);
  logic fill_wait;

  // Chunk with the byte read in the previous cycle merged in.
  logic [63:0] chunk_full;
  always_comb begin
    chunk_full = chunk;
    if (fill_wait) chunk_full[8*(cidx-CW'(1)) +: 8] = h_rdata;
  end

  always_ff @(posedge clk) begin
    dbyte_q <= dict_byte;
    dsel_q <= dict_sel;
    if (rst) begin
      src_hi <= '0; src_lo <= '0; dst_hi <= '0; dst_lo <= '0;
      output_limit <= 9'd256; stop_ok <= 1'b0;
      state <= S_IDLE; wpos <= '0; lit_pend <= '0; start_adj <= '0;
      num_adj <= '0; stop_seen <= 1'b0; err <= ghc_pkg::ST_OK;
      out_valid <= 1'b0; last_q <= 1'b0; fill_wait <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ghc_pkg::REG_SRC_HI: src_hi <= cfg_data;
          ghc_pkg::REG_SRC_LO: src_lo <= cfg_data;
          ghc_pkg::REG_DST_HI: dst_hi <= cfg_data;
          ghc_pkg::REG_DST_LO: dst_lo <= cfg_data;
          ghc_pkg::REG_LIMIT:  output_limit <= cfg_data[8:0];
          ghc_pkg::REG_STOP:   stop_ok <= cfg_data[0];
          default: ;
        endcase
      end
      // The status state reloads the output itself when it is taken.
      if (out_acc && state != S_END) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            last_q <= in_data.last_byte;
            emit_pos <= wpos;
            state <= S_EMIT;
            zero_run <= 1'b0;
            if (err != ghc_pkg::ST_OK) begin
              if (lit_pend != 7'd0) lit_pend <= lit_pend - 7'd1;
            end else if (stop_seen) begin
            end else if (lit_pend != 7'd0) begin
              wpos <= wpos + 1'b1;
              lit_pend <= lit_pend - 7'd1;
            end else if (!cb[7]) begin
              if (cb[6:0] > ghc_pkg::LITERAL_MAX) err <= ghc_pkg::ST_RSV_LITERAL;
              else if (cb[6:0] != 7'd0) begin
                lit_pend <= cb[6:0];
                if ((PW+1)'(wpos) + (PW+1)'(cb[6:0]) > (PW+1)'(limit))
                  err <= ghc_pkg::ST_OVERFLOW;
              end
            end else if (cb == ghc_pkg::HALT_BYTE) begin
              if (stop_ok) stop_seen <= 1'b1; else err <= ghc_pkg::ST_BAD_STOP;
            end else if (cb[7:4] == 4'h8) begin
              if ((PW+1)'(wpos) + (PW+1)'(cb[3:0]) + (PW+1)'(2) > (PW+1)'(limit))
                err <= ghc_pkg::ST_OVERFLOW;
              else begin
                zero_run <= 1'b1;
                remain <= PW'(cb[3:0]) + PW'(2);
                state <= S_WR;
              end
            end else if (cb[7:5] == 3'b101) begin
              start_adj <= (s_sum > 11'(ghc_pkg::ADJUST_MAX)) ? ghc_pkg::ADJUST_MAX
                                                               : s_sum[9:0];
              num_adj <= (n_sum > 11'(ghc_pkg::ADJUST_MAX)) ? ghc_pkg::ADJUST_MAX
                                                             : n_sum[9:0];
            end else if (cb[7:6] == 2'b11) begin
              start_adj <= '0;
              num_adj <= '0;
              if (bl_dist > here) err <= ghc_pkg::ST_TOO_FAR;
              else if (12'(wpos) + 12'(bl_len) > 12'(limit)) err <= ghc_pkg::ST_OVERFLOW;
              else begin
                src_ptr <= here_w - (PW+2)'(bl_dist);
                remain <= PW'(bl_len);
                state <= S_RD;
              end
            end else begin
              err <= ghc_pkg::ST_RSV_CODE;
            end
          end
        end
        S_RD: state <= S_WR;
        S_WR: begin
          wpos <= wpos + 1'b1;
          src_ptr <= src_ptr + 1'b1;
          remain <= remain - 1'b1;
          if (remain == PW'(1)) state <= S_EMIT;
          else if (!zero_run) state <= S_RD;
        end
        S_EMIT: begin
          if (!out_valid || out_acc) begin
            if (wpos != emit_pos) begin
              cnt <= take;
              cidx <= '0;
              chunk <= '0;
              fill_wait <= 1'b0;
              state <= S_FILL;
            end else if (last_q) begin
              state <= S_END;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_FILL: begin
          // Reads are issued one byte per cycle; data lands in the next cycle.
          if (fill_wait) begin
            chunk <= chunk_full;
          end
          if (cidx == cnt) begin
            out_valid <= 1'b1;
            out_data.data_bytes <= chunk_full;
            out_data.byte_count <= 4'(cnt);
            out_data.packet_end <= 1'b0;
            out_data.status <= ghc_pkg::ST_OK;
            out_data.total_length <= '0;
            out_data.run_last <= !last_q && (emit_pos + PW'(cnt) == wpos);
            emit_pos <= emit_pos + PW'(cnt);
            state <= S_EMIT;
          end else begin
            cidx <= cidx + 1'b1;
            fill_wait <= 1'b1;
          end
        end
        S_END: begin
          if (!out_valid || out_acc) begin
            out_valid <= 1'b1;
            out_data.data_bytes <= '0;
            out_data.byte_count <= '0;
            out_data.run_last <= 1'b1;
            out_data.packet_end <= 1'b1;
            if (lit_pend != 7'd0 && (err == ghc_pkg::ST_OK || err == ghc_pkg::ST_OVERFLOW)) begin
              out_data.status <= ghc_pkg::ST_LIT_OVERRUN;
              out_data.total_length <= '0;
            end else begin
              out_data.status <= err;
              out_data.total_length <= (err == ghc_pkg::ST_OK) ? 9'(wpos) : 9'd0;
            end
            wpos <= '0; lit_pend <= '0; start_adj <= '0; num_adj <= '0;
            stop_seen <= 1'b0; err <= ghc_pkg::ST_OK;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_acc) else $error("accepted while busy");
  a_wpos_bound: assert property (@(posedge clk) disable iff (rst)
    wpos <= MAXP) else $error("write position past history");
  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    emit_pos <= wpos || state == S_IDLE || state == S_END)
    else $error("emit past write position");
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.byte_count <= 4'(CHUNK_BYTES)) else $error("chunk too big");
endmodule
`default_nettype wire
